### design/deq_pkg.sv
package deq_pkg;

   // item field widths
   localparam int DATA_W   = 32;
   localparam int CMD_W    = 3;
   localparam int STATUS_W = 2;

   // default number of ring entries
   localparam int DEPTH_DEFAULT = 8;

   // stream payload widths, rounded up to whole bytes
   localparam int REQ_FIELDS_W = CMD_W + DATA_W;
   localparam int REQ_TDATA_W  = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = DATA_W + STATUS_W + 2;
   localparam int RSP_TDATA_W  = ((RSP_FIELDS_W + 7) / 8) * 8;

   // command codes
   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH_FRONT = 3'd0,
      CMD_PUSH_BACK  = 3'd1,
      CMD_POP_FRONT  = 3'd2,
      CMD_POP_BACK   = 3'd3,
      CMD_PEEK_FRONT = 3'd4,
      CMD_PEEK_BACK  = 3'd5
   } cmd_type;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_UNDERFLOW = 2'd2
   } status_type;

endpackage

### design/deq_ram.sv
module deq_ram #(
   parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(DEPTH)-1:0]      wr_addr,
   input  logic [deq_pkg::DATA_W-1:0]    wr_data,
   input  logic                          rd_en,
   input  logic [$clog2(DEPTH)-1:0]      rd_addr,
   output logic [deq_pkg::DATA_W-1:0]    rd_data
);
   import deq_pkg::*;

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port, holds its data between reads
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/double_ended_ring_queue_unit.sv
// channel  | direction | tdata fields (low bit first)                 | transfer when
// ---------+-----------+-----------------------------------------------+-----------------------
// req_     | in        | command[2:0], push_value[34:3], zero pad      | req_tvalid & req_tready
// rsp_     | out       | peek_value[31:0], status[33:32], empty[34],   | rsp_tvalid & rsp_tready
//          |           | full[35], zero pad                            |
//
// One command is taken per cycle while req_tready is high; its result passes through the
// read stage and then the output register. Pointers and occupancy update in the transfer
// cycle, and a peek reads the ring memory then; the memory read is registered.
// reset (synchronous) empties the queue; ring entries are not cleared.
// A stalled result holds one command in the read stage, after which req_tready drops.
module double_ended_ring_queue_unit #(
   parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // command transfer
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [deq_pkg::REQ_TDATA_W-1:0]   req_tdata,  // command, push_value
   // result transfer
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [deq_pkg::RSP_TDATA_W-1:0]   rsp_tdata   // peek_value, status, empty, full
);
   import deq_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int OCC_W = $clog2(DEPTH + 1);
   localparam logic [IDX_W-1:0] LAST_SLOT  = IDX_W'(DEPTH - 1);
   localparam logic [OCC_W-1:0] FULL_COUNT = OCC_W'(DEPTH);
   localparam logic [OCC_W-1:0] ONE_COUNT  = OCC_W'(1);

   function automatic logic [IDX_W-1:0] slot_next(input logic [IDX_W-1:0] i);
      return (i == LAST_SLOT) ? '0 : i + IDX_W'(1);
   endfunction

   function automatic logic [IDX_W-1:0] slot_prev(input logic [IDX_W-1:0] i);
      return (i == '0) ? LAST_SLOT : i - IDX_W'(1);
   endfunction

   // request fields
   cmd_type             cmd;
   logic [DATA_W-1:0]   push_value;

   // pointer state
   logic [IDX_W-1:0]    head_ff, head_in;
   logic [IDX_W-1:0]    tail_ff, tail_in;
   logic [OCC_W-1:0]    occ_ff, occ_in;

   // memory access
   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   logic                rd_en;
   logic [IDX_W-1:0]    rd_addr;
   logic [DATA_W-1:0]   rd_data;

   // per-command results
   status_type          status_now;
   logic                peek_ok_now;

   // read stage
   logic                s1_valid_ff, s1_valid_in;
   logic                s1_peek_ok_ff;
   status_type          s1_status_ff;
   logic                s1_empty_ff;
   logic                s1_full_ff;
   logic                s1_move;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]   rsp_peek_ff;
   status_type          rsp_status_ff;
   logic                rsp_empty_ff;
   logic                rsp_full_ff;

   logic                req_fire;

   assign cmd        = cmd_type'(req_tdata[CMD_W-1:0]);
   assign push_value = req_tdata[CMD_W +: DATA_W];

   // handshake
   assign s1_move    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_move;
   assign req_fire   = req_tvalid && req_tready;

   // command decode and pointer update
   always_comb begin
      head_in     = head_ff;
      tail_in     = tail_ff;
      occ_in      = occ_ff;
      wr_en       = 1'b0;
      wr_addr     = head_ff;
      rd_en       = 1'b0;
      rd_addr     = head_ff;
      status_now  = ST_OK;
      peek_ok_now = 1'b0;
      unique case (cmd) inside
         CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
            if (occ_ff == FULL_COUNT) begin
               status_now = ST_OVERFLOW;
            end else begin
               if (occ_ff == '0) begin
                  head_in = '0;
                  tail_in = '0;
                  wr_addr = '0;
               end else if (cmd == CMD_PUSH_FRONT) begin
                  head_in = slot_prev(head_ff);
                  wr_addr = head_in;
               end else begin
                  tail_in = slot_next(tail_ff);
                  wr_addr = tail_in;
               end
               wr_en  = req_fire;
               occ_in = occ_ff + ONE_COUNT;
            end
         end
         CMD_POP_FRONT, CMD_POP_BACK: begin
            if (occ_ff == '0) begin
               status_now = ST_UNDERFLOW;
            end else begin
               occ_in = occ_ff - ONE_COUNT;
               if (occ_ff == ONE_COUNT) begin
                  head_in = '0;
                  tail_in = '0;
               end else if (cmd == CMD_POP_FRONT) begin
                  head_in = slot_next(head_ff);
               end else begin
                  tail_in = slot_prev(tail_ff);
               end
            end
         end
         CMD_PEEK_FRONT, CMD_PEEK_BACK: begin
            if (occ_ff == '0) begin
               status_now = ST_UNDERFLOW;
            end else begin
               peek_ok_now = 1'b1;
               rd_en       = req_fire;
               rd_addr     = (cmd == CMD_PEEK_FRONT) ? head_ff : tail_ff;
            end
         end
         default: begin
            // unused codes change nothing
         end
      endcase
   end

   // pointer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         occ_ff  <= '0;
      end else if (req_fire) begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         occ_ff  <= occ_in;
      end
   end

   // ring memory
   deq_ram #(
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (push_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // read stage control
   always_comb begin
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   // read stage payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_peek_ok_ff <= peek_ok_now;
         s1_status_ff  <= status_now;
         s1_empty_ff   <= (occ_in == '0);
         s1_full_ff    <= (occ_in == FULL_COUNT);
      end
   end

   // output register control
   always_comb begin
      if (s1_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // output register payload
   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_peek_ff   <= s1_peek_ok_ff ? rd_data : '0;
         rsp_status_ff <= s1_status_ff;
         rsp_empty_ff  <= s1_empty_ff;
         rsp_full_ff   <= s1_full_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - RSP_FIELDS_W){1'b0}},
                        rsp_full_ff, rsp_empty_ff, rsp_status_ff, rsp_peek_ff};

   // checks
   assert property (@(posedge clock) disable iff (reset)
      occ_ff <= FULL_COUNT)
      else $error("occupancy above depth");

   assert property (@(posedge clock) disable iff (reset)
      (occ_ff == '0) |-> (head_ff == '0 && tail_ff == '0))
      else $error("pointers not parked on empty queue");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_empty_ff && rsp_full_ff))
      else $error("empty and full reported together");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == ST_OVERFLOW) |-> rsp_full_ff)
      else $error("overflow without full queue");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == ST_UNDERFLOW) |-> (rsp_empty_ff && rsp_peek_ff == '0))
      else $error("underflow without empty queue");

endmodule

### dv/deque_result_checker.sv
`timescale 1ns / 100ps

module deque_result_checker #(
   parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   input  logic [deq_pkg::REQ_TDATA_W-1:0]   req_tdata,  // command, push_value
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [deq_pkg::RSP_TDATA_W-1:0]   rsp_tdata,  // peek_value, status, empty, full
   output int                                mismatch_count,
   output int                                results_pending
);

   import deq_pkg::*;

   localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int REPORT_MAX = 10;

   typedef struct packed {
      logic [DATA_W-1:0] peek_value;
      status_type        status;
      logic              empty_flag;
      logic              full_flag;
   } deque_result_type;

   // shadow copy of the queue
   logic [DATA_W-1:0] ring_entries [DEPTH];
   logic [IDX_W-1:0]  front_slot;
   logic [IDX_W-1:0]  back_slot;
   logic [IDX_W:0]    fill_level;

   deque_result_type expected_results [$];
   int               result_index;

   function automatic logic [IDX_W-1:0] slot_after(input logic [IDX_W-1:0] slot);
      return (int'(slot) + 1 >= DEPTH) ? '0 : slot + IDX_W'(1);
   endfunction

   function automatic logic [IDX_W-1:0] slot_before(input logic [IDX_W-1:0] slot);
      return (slot == '0) ? IDX_W'(DEPTH - 1) : slot - IDX_W'(1);
   endfunction

   // apply one command to the shadow queue and return the result it should give
   function automatic deque_result_type predict_command(
      input logic [CMD_W-1:0]  cmd,
      input logic [DATA_W-1:0] value
   );
      deque_result_type res;
      res        = '0;
      res.status = ST_OK;
      case (cmd)
         CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
            if (fill_level >= DEPTH) begin
               res.status = ST_OVERFLOW;
            end else begin
               // first element always lands in slot zero
               if (fill_level == 0) begin
                  front_slot      = '0;
                  back_slot       = '0;
                  ring_entries[0] = value;
               end else if (cmd == CMD_PUSH_FRONT) begin
                  front_slot               = slot_before(front_slot);
                  ring_entries[front_slot] = value;
               end else begin
                  back_slot               = slot_after(back_slot);
                  ring_entries[back_slot] = value;
               end
               fill_level = fill_level + 1'b1;
            end
         end
         CMD_POP_FRONT, CMD_POP_BACK: begin
            if (fill_level == 0) begin
               res.status = ST_UNDERFLOW;
            end else begin
               fill_level = fill_level - 1'b1;
               // emptied queue restarts at slot zero
               if (fill_level == 0) begin
                  front_slot = '0;
                  back_slot  = '0;
               end else if (cmd == CMD_POP_FRONT) begin
                  front_slot = slot_after(front_slot);
               end else begin
                  back_slot = slot_before(back_slot);
               end
            end
         end
         CMD_PEEK_FRONT, CMD_PEEK_BACK: begin
            if (fill_level == 0) begin
               res.status = ST_UNDERFLOW;
            end else begin
               res.peek_value = ring_entries[(cmd == CMD_PEEK_FRONT) ? front_slot : back_slot];
            end
         end
         default: begin
            // unused codes leave the queue alone
         end
      endcase
      res.empty_flag = (fill_level == 0);
      res.full_flag  = (fill_level >= DEPTH);
      return res;
   endfunction

   // compare result transfers, then record the expectation of a command transfer
   always @(posedge clock) begin : monitor
      deque_result_type seen;
      deque_result_type want;
      deque_result_type predicted;
      if (reset) begin
         front_slot      = '0;
         back_slot       = '0;
         fill_level      = '0;
         result_index    = 0;
         mismatch_count  = 0;
         results_pending = 0;
         expected_results.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen.peek_value = rsp_tdata[DATA_W-1:0];
            seen.status     = status_type'(rsp_tdata[DATA_W +: STATUS_W]);
            seen.empty_flag = rsp_tdata[DATA_W + STATUS_W];
            seen.full_flag  = rsp_tdata[DATA_W + STATUS_W + 1];
            if (expected_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX)
                  $display("unexpected result: peek %h status %0d empty %b full %b",
                           seen.peek_value, seen.status, seen.empty_flag, seen.full_flag);
            end else begin
               want = expected_results.pop_front();
               if (seen !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_MAX) begin
                     $display("result %0d: expected peek %h status %0d empty %b full %b",
                              result_index, want.peek_value, want.status, want.empty_flag,
                              want.full_flag);
                     $display("result %0d: got      peek %h status %0d empty %b full %b",
                              result_index, seen.peek_value, seen.status, seen.empty_flag,
                              seen.full_flag);
                  end
               end
               result_index++;
            end
         end
         if (req_tvalid && req_tready) begin
            predicted = predict_command(req_tdata[CMD_W-1:0], req_tdata[CMD_W +: DATA_W]);
            expected_results.insert(expected_results.size(), predicted);
         end
         results_pending = expected_results.size();
      end
   end

endmodule

### dv/double_ended_ring_queue_unit_test.sv
`timescale 1ns / 100ps

module double_ended_ring_queue_unit_test;

   import deq_pkg::*;

   localparam int DEPTH          = DEPTH_DEFAULT;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TAIL_CYCLES    = 8;
   localparam int PHASE_ITEMS    = 400;
   localparam int BURST_LEN      = 16;

   // codes outside the command set
   localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd6;
   localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

   localparam logic [DATA_W-1:0] VALUE_MIN = 32'h8000_0000;
   localparam logic [DATA_W-1:0] VALUE_MAX = 32'h7fff_ffff;

   typedef enum int { FILL_BIAS, DRAIN_BIAS, MIXED_BIAS } burst_bias_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;  // command, push_value
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;        // peek_value, status, empty, full

   int          mismatch_count;
   int          results_pending;
   int unsigned req_idle_pct = 0;
   int unsigned rsp_idle_pct = 0;
   int          quiet_cycles = 0;

   double_ended_ring_queue_unit #(
      .DEPTH (DEPTH)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   deque_result_checker #(
      .DEPTH (DEPTH)
   ) checker_inst (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .mismatch_count  (mismatch_count),
      .results_pending (results_pending)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver stalls at random
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // one command transfer, entered and left at a falling edge
   task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] value);
      logic [REQ_TDATA_W-1:0] word;
      word                   = '0;
      word[CMD_W-1:0]        = cmd;
      word[CMD_W +: DATA_W]  = value;
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // hold off the sender until every result is back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (results_pending != 0);
   endtask

   function automatic logic [CMD_W-1:0] pick_command(input burst_bias_type bias);
      int unsigned roll;
      int unsigned push_cut;
      int unsigned pop_cut;
      roll = $urandom_range(99);
      case (bias)
         FILL_BIAS: begin
            push_cut = 65;
            pop_cut  = 85;
         end
         DRAIN_BIAS: begin
            push_cut = 25;
            pop_cut  = 75;
         end
         default: begin
            push_cut = 40;
            pop_cut  = 70;
         end
      endcase
      if (roll < 3)
         return roll[0] ? CMD_UNUSED_HI : CMD_UNUSED_LO;
      if (roll < push_cut)
         return $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
      if (roll < pop_cut)
         return $urandom_range(1) ? CMD_POP_BACK : CMD_POP_FRONT;
      return $urandom_range(1) ? CMD_PEEK_BACK : CMD_PEEK_FRONT;
   endfunction

   // mostly random words, with the signed extremes mixed in
   function automatic logic [DATA_W-1:0] pick_value();
      case ($urandom_range(9))
         0:       return VALUE_MIN;
         1:       return VALUE_MAX;
         2:       return '0;
         3:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // bursts that fill, drain or mix, so full and empty are both reached often
   task automatic run_random_phase(input int item_count);
      burst_bias_type bias;
      bias = MIXED_BIAS;
      for (int n = 0; n < item_count; n++) begin
         if (n % BURST_LEN == 0)
            bias = burst_bias_type'($urandom_range(2));
         send_command(pick_command(bias), pick_value());
      end
      drain_results();
   endtask

   initial begin
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      req_idle_pct = 25;
      rsp_idle_pct = 86;

      // underflow on every end of an empty queue
      send_command(CMD_POP_FRONT, VALUE_MAX);
      send_command(CMD_PEEK_BACK, VALUE_MIN);
      send_command(CMD_POP_BACK, '0);
      send_command(CMD_PEEK_FRONT, '1);
      // push into empty, peek both ends, pop that empties
      send_command(CMD_PUSH_BACK, VALUE_MAX);
      send_command(CMD_PEEK_FRONT, '0);
      send_command(CMD_PEEK_BACK, '0);
      send_command(CMD_POP_BACK, '0);
      // fill to the brim from both ends
      send_command(CMD_PUSH_FRONT, VALUE_MIN);
      send_command(CMD_PUSH_FRONT, '1);
      send_command(CMD_PUSH_BACK, '0);
      for (int n = 3; n < DEPTH; n++)
         send_command(n[0] ? CMD_PUSH_FRONT : CMD_PUSH_BACK, $urandom);
      // overflow from both ends, then peeks and unused codes on a full queue
      send_command(CMD_PUSH_FRONT, VALUE_MAX);
      send_command(CMD_PUSH_BACK, VALUE_MIN);
      send_command(CMD_PEEK_FRONT, '0);
      send_command(CMD_PEEK_BACK, '0);
      send_command(CMD_UNUSED_LO, '1);
      send_command(CMD_UNUSED_HI, VALUE_MAX);
      send_command(CMD_POP_FRONT, '0);
      send_command(CMD_POP_BACK, '0);
      drain_results();

      run_random_phase(PHASE_ITEMS);

      req_idle_pct = 86;
      rsp_idle_pct = 25;
      run_random_phase(PHASE_ITEMS);

      req_idle_pct = 0;
      rsp_idle_pct = 0;
      run_random_phase(PHASE_ITEMS);

      repeat (TAIL_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && results_pending == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
